@@ rtl/core/wsd_pkg.sv @@
`timescale 1ns / 1ps

package wsd_pkg;

   typedef enum logic [1:0] {
      KIND_DATA        = 2'd0,
      KIND_EMPTY       = 2'd1,
      KIND_PEER_CLOSE  = 2'd2,
      KIND_LOCAL_CLOSE = 2'd3
   } kind_type;

   typedef struct packed {
      logic       command;
      logic [7:0] byte_in;
   } req_payload_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data_byte;
      logic       last_in_frame;
      logic       send_close_frame;
   } rsp_payload_type;

   // one parsed result between the parser and the output register
   typedef struct packed {
      logic            valid;
      rsp_payload_type payload;
   } result_type;

endpackage

@@ rtl/core/wsd_stream_if.sv @@
`timescale 1ns / 1ps

interface wsd_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [7:0] byte_in;

   modport source (output valid, output command, output byte_in, input ready);
   modport sink   (input valid, input command, input byte_in, output ready);
endinterface

interface wsd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] data_byte;
   logic       last_in_frame;
   logic       send_close_frame;

   modport source (output valid, output kind, output data_byte, output last_in_frame,
                   output send_close_frame, input ready);
   modport sink   (input valid, input kind, input data_byte, input last_in_frame,
                   input send_close_frame, output ready);
endinterface

@@ rtl/core/websocket_frame_deframer_top.sv @@
`timescale 1ns / 1ps
// channel    dir  payload                                            handshake
// req_chan   in   command, byte_in[7:0]                              valid/ready
// rsp_chan   out  kind[1:0], data_byte[7:0], last_in_frame,          valid/ready
//                 send_close_frame
//
// One transaction per cycle while rsp_chan does not stall: input register, parser logic, output register.
// A transaction's result, where it has one, passes from the input register through the parser into the output register.
// Synchronous active-high reset returns the parser to the first header byte.
// A stalled output holds the input stage; req_chan.ready is high while the input register is empty or can_load.

module websocket_frame_deframer_top
   import wsd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   wsd_req_if.sink   req_chan,
   wsd_rsp_if.source rsp_chan
);

   logic            in_valid_ff, in_valid_in;
   req_payload_type in_item_ff, in_item_in;
   logic            can_load;
   logic            advance;
   result_type      result;

   assign advance        = in_valid_ff && can_load;
   assign req_chan.ready = !in_valid_ff || can_load;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_chan.ready) begin
         in_valid_in        = req_chan.valid;
         in_item_in.command = req_chan.command;
         in_item_in.byte_in = req_chan.byte_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      in_item_ff <= in_item_in;
   end

   wsd_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (in_item_ff),
      .result (result)
   );

   wsd_rsp_reg u_rsp_reg (
      .clock    (clock),
      .reset    (reset),
      .result   (result),
      .can_load (can_load),
      .rsp_chan (rsp_chan)
   );

endmodule

@@ rtl/core/wsd_parser.sv @@
`timescale 1ns / 1ps

module wsd_parser
   import wsd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            fire,
   input  req_payload_type item,
   output result_type      result
);

   typedef enum logic [2:0] {
      PH_HDR0 = 3'd0,
      PH_HDR1 = 3'd1,
      PH_EXT  = 3'd2,
      PH_MASK = 3'd3,
      PH_DATA = 3'd4
   } phase_type;

   localparam logic [6:0] LEN_EXT16    = 7'd126;
   localparam logic [6:0] LEN_EXT64    = 7'd127;
   localparam logic [3:0] OPCODE_CLOSE = 4'h8;
   localparam logic [2:0] EXT16_LEFT   = 3'd1;
   localparam logic [2:0] EXT64_LEFT   = 3'd7;

   phase_type   phase_ff, phase_in;
   logic [2:0]  ext_left_ff, ext_left_in;
   logic [63:0] payload_left_ff, payload_left_in;
   logic [31:0] mask_key_ff, mask_key_in;
   logic [1:0]  mask_pos_ff, mask_pos_in;
   logic        is_masked_ff, is_masked_in;
   logic        local_sent_ff, local_sent_in;
   logic        closed_ff, closed_in;

   always_comb begin
      logic [7:0]  b;
      logic [6:0]  short_len;
      logic [63:0] ext_len;
      logic [63:0] len_value;
      logic [63:0] hdr_len;
      logic        len_end;
      logic        len_masked;
      logic        hdr_end;
      logic [1:0]  pos_next;
      logic [7:0]  key_byte;
      logic [63:0] left_next;

      b          = item.byte_in;
      short_len  = b[6:0];
      ext_len    = {payload_left_ff[55:0], b};
      len_value  = '0;
      hdr_len    = payload_left_ff;
      len_end    = 1'b0;
      len_masked = is_masked_ff;
      hdr_end    = 1'b0;
      pos_next   = mask_pos_ff + 2'd1;
      left_next  = payload_left_ff - 64'd1;
      key_byte   = '0;

      phase_in        = phase_ff;
      ext_left_in     = ext_left_ff;
      payload_left_in = payload_left_ff;
      mask_key_in     = mask_key_ff;
      mask_pos_in     = mask_pos_ff;
      is_masked_in    = is_masked_ff;
      local_sent_in   = local_sent_ff;
      closed_in       = closed_ff;
      result          = '0;

      unique case (mask_pos_ff)
         2'd0: key_byte = mask_key_ff[31:24];
         2'd1: key_byte = mask_key_ff[23:16];
         2'd2: key_byte = mask_key_ff[15:8];
         2'd3: key_byte = mask_key_ff[7:0];
         default: key_byte = '0;
      endcase

      if (fire && !closed_ff) begin
         if (item.command) begin
            // local close does not disturb parsing
            local_sent_in                   = 1'b1;
            result.valid                    = 1'b1;
            result.payload.kind             = KIND_LOCAL_CLOSE;
            result.payload.send_close_frame = 1'b1;
         end else begin
            unique case (phase_ff)
               PH_HDR1: begin
                  is_masked_in = b[7];
                  len_masked   = b[7];
                  if (short_len == LEN_EXT16) begin
                     payload_left_in = '0;
                     ext_left_in     = EXT16_LEFT;
                     phase_in        = PH_EXT;
                  end else if (short_len == LEN_EXT64) begin
                     payload_left_in = '0;
                     ext_left_in     = EXT64_LEFT;
                     phase_in        = PH_EXT;
                  end else begin
                     len_value       = {57'd0, short_len};
                     payload_left_in = len_value;
                     len_end         = 1'b1;
                  end
               end
               PH_EXT: begin
                  payload_left_in = ext_len;
                  if (ext_left_ff == 3'd0) begin
                     len_value = ext_len;
                     len_end   = 1'b1;
                  end else begin
                     ext_left_in = ext_left_ff - 3'd1;
                  end
               end
               PH_MASK: begin
                  mask_key_in = {mask_key_ff[23:0], b};
                  mask_pos_in = pos_next;
                  if (pos_next == 2'd0) begin
                     hdr_end = 1'b1;
                     hdr_len = payload_left_ff;
                  end
               end
               PH_DATA: begin
                  payload_left_in = left_next;
                  if (is_masked_ff) begin
                     mask_pos_in = pos_next;
                  end
                  result.valid                 = 1'b1;
                  result.payload.kind          = KIND_DATA;
                  result.payload.data_byte     = is_masked_ff ? (b ^ key_byte) : b;
                  result.payload.last_in_frame = (left_next == 64'd0);
                  if (left_next == 64'd0) begin
                     phase_in = PH_HDR0;
                  end
               end
               default: begin
                  // first header byte; unused phase codes land here as well
                  if (b[3:0] == OPCODE_CLOSE) begin
                     closed_in                       = 1'b1;
                     phase_in                        = PH_HDR0;
                     result.valid                    = 1'b1;
                     result.payload.kind             = KIND_PEER_CLOSE;
                     result.payload.send_close_frame = !local_sent_ff;
                  end else begin
                     phase_in = PH_HDR1;
                  end
               end
            endcase

            if (len_end) begin
               if (len_masked) begin
                  mask_pos_in = 2'd0;
                  phase_in    = PH_MASK;
               end else begin
                  hdr_end = 1'b1;
                  hdr_len = len_value;
               end
            end

            if (hdr_end) begin
               mask_pos_in = 2'd0;
               if (hdr_len == 64'd0) begin
                  phase_in            = PH_HDR0;
                  result.valid        = 1'b1;
                  result.payload.kind = KIND_EMPTY;
               end else begin
                  phase_in = PH_DATA;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HDR0;
         ext_left_ff     <= '0;
         payload_left_ff <= '0;
         mask_key_ff     <= '0;
         mask_pos_ff     <= '0;
         is_masked_ff    <= 1'b0;
         local_sent_ff   <= 1'b0;
         closed_ff       <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         ext_left_ff     <= ext_left_in;
         payload_left_ff <= payload_left_in;
         mask_key_ff     <= mask_key_in;
         mask_pos_ff     <= mask_pos_in;
         is_masked_ff    <= is_masked_in;
         local_sent_ff   <= local_sent_in;
         closed_ff       <= closed_in;
      end
   end

   a_closed_sticky: assert property (@(posedge clock) disable iff (reset)
      closed_ff |=> closed_ff)
      else $error("stream reopened after peer close");

   a_local_sticky: assert property (@(posedge clock) disable iff (reset)
      local_sent_ff |=> local_sent_ff)
      else $error("local close flag dropped");

   a_data_nonzero: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA) |-> (payload_left_ff != 64'd0))
      else $error("payload phase with nothing left");

   a_no_result_when_closed: assert property (@(posedge clock) disable iff (reset)
      closed_ff |-> !result.valid)
      else $error("result produced after stream closed");

endmodule

@@ rtl/core/wsd_rsp_reg.sv @@
`timescale 1ns / 1ps

module wsd_rsp_reg
   import wsd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  result_type result,
   output logic       can_load,
   wsd_rsp_if.source  rsp_chan
);

   logic            valid_ff, valid_in;
   rsp_payload_type payload_ff, payload_in;

   assign can_load = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in   = valid_ff;
      payload_in = payload_ff;
      if (can_load) begin
         valid_in   = result.valid;
         payload_in = result.payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      payload_ff <= payload_in;
   end

   assign rsp_chan.valid            = valid_ff;
   assign rsp_chan.kind             = payload_ff.kind;
   assign rsp_chan.data_byte        = payload_ff.data_byte;
   assign rsp_chan.last_in_frame    = payload_ff.last_in_frame;
   assign rsp_chan.send_close_frame = payload_ff.send_close_frame;

endmodule
